### rtl/sh_eval_pkg.sv
package sh_eval_pkg;

    localparam int MAX_DEGREE   = 8;
    localparam int SERIES_TERMS = 8;
    localparam int DEG_W        = $clog2(MAX_DEGREE + 1);
    localparam int ANG_W        = 34 + DEG_W;
    localparam int RED_W        = ANG_W + 2;
    localparam int FAC_W        = 32;
    localparam int OUT_W        = 24;
    localparam int CFG_W        = 4;

    localparam longint TWO_PI_Q30       = 64'sd6746518852;
    localparam longint HALF_PI_Q30      = 64'sd1686629713;
    localparam longint ONE_Q30          = 64'sd1073741824;
    localparam longint INV_SQRT_4PI_Q24 = 64'sd4732765;

    // multiples of 2pi added to a negative angle so that it becomes non-negative
    localparam int RED_K     = int'(((64'sd1 <<< (ANG_W - 1)) + TWO_PI_Q30 - 64'sd1)
                                    / TWO_PI_Q30);
    localparam int RED_STEPS = $clog2(2 * RED_K + 2);
    localparam int TRIG_LAT  = RED_STEPS + 2 * SERIES_TERMS + 5;
    localparam int PIPE_DEPTH = 1 + TRIG_LAT + 2 * MAX_DEGREE + 2;

    localparam logic [CFG_W-1:0] DEGREE_RESET = 4'd6;

    typedef logic [DEG_W-1:0]        t_deg;
    typedef logic signed [ANG_W-1:0] t_ang;
    typedef logic signed [RED_W-1:0] t_red;
    typedef logic signed [33:0]      t_q30;
    typedef logic signed [47:0]      t_fx;
    typedef logic signed [OUT_W-1:0] t_out;
    typedef logic [(MAX_DEGREE+1)*FAC_W-1:0] t_fac_row;

    typedef struct packed {
        t_deg degree;
        t_deg order_mag;
        logic flip;
        logic invalid;
    } t_side;

    typedef struct packed {
        t_fx   cur;
        t_fx   prev;
        t_fx   x;
        t_fx   sn;
        t_fx   cp;
        t_fx   sp;
        t_side side;
    } t_leg;

    function automatic logic [31:0] mag_clamp(input t_fx a);
        logic [47:0] m;
        m = a[47] ? 48'(-a) : 48'(a);
        return (m > 48'h0000_8000_0000) ? 32'h8000_0000 : m[31:0];
    endfunction

    // operands clamped to +-2^31, product rounded half away from zero
    function automatic t_fx mul_fx(input t_fx a, input t_fx b, input int sh);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [63:0] prod;
        logic        neg;
        ma   = mag_clamp(a);
        mb   = mag_clamp(b);
        neg  = a[47] ^ b[47];
        prod = 64'(ma) * 64'(mb);
        prod = (prod + (64'd1 << (sh - 1))) >> sh;
        return neg ? -t_fx'(prod) : t_fx'(prod);
    endfunction

    function automatic t_fx round_shift(input t_fx v, input int sh);
        logic [47:0] m;
        m = v[47] ? 48'(-v) : 48'(v);
        m = (m + (48'd1 << (sh - 1))) >> sh;
        return v[47] ? -t_fx'(m) : t_fx'(m);
    endfunction

    // truncating division of a value below 2^32 in magnitude by a constant,
    // through its rounded-up reciprocal
    function automatic t_fx div_const(input t_fx p, input logic [32:0] recip, input int sh);
        logic [47:0] m;
        logic [64:0] prod;
        logic [31:0] q;
        m    = p[47] ? 48'(-p) : 48'(p);
        prod = 65'(m[31:0]) * 65'(recip);
        q    = 32'(prod >> sh);
        return p[47] ? -t_fx'(q) : t_fx'(q);
    endfunction

    function automatic t_out to_out(input t_fx v);
        t_fx r;
        r = round_shift(v, 4);
        if (r > t_fx'(8388607)) return t_out'(8388607);
        if (r < -t_fx'(8388608)) return t_out'(-8388608);
        return t_out'(r);
    endfunction

    // floor(2^24 * sqrt(p / q)), bit by bit
    function automatic logic [31:0] root_ratio(input longint unsigned p,
                                               input longint unsigned q);
        logic [127:0] lim;
        logic [127:0] sq;
        logic [31:0]  r;
        logic [31:0]  c;
        int           b;
        r   = '0;
        lim = 128'(p) << 48;
        if (q == 0) return '0;
        for (b = 31; b >= 0; b--) begin
            c  = r | (32'd1 << b);
            sq = 128'(c) * 128'(c) * 128'(q);
            if (sq <= lim) r = c;
        end
        return r;
    endfunction

    // recurrence factors of one step for every order
    function automatic t_fac_row factor_row(input int step, input logic second);
        t_fac_row          row;
        longint unsigned   k;
        longint unsigned   m;
        int                i;
        row = '0;
        k   = 64'(step);
        for (i = 0; i <= MAX_DEGREE; i++) begin
            m = 64'(i);
            if (!second) begin
                if (k <= m)
                    row[i*FAC_W +: FAC_W] = root_ratio(2*k + 1, 2*k);
                else if (k == m + 1)
                    row[i*FAC_W +: FAC_W] = root_ratio(2*m + 3, 1);
                else
                    row[i*FAC_W +: FAC_W] = root_ratio(4*k*k - 1, k*k - m*m);
            end else if (k >= m + 2) begin
                row[i*FAC_W +: FAC_W] = root_ratio((4*k*k - 1) * ((k-1)*(k-1) - m*m),
                                                   (k*k - m*m) * (4*(k-1)*(k-1) - 1));
            end
        end
        return row;
    endfunction

endpackage

### rtl/sh_eval_trig.sv
module sh_eval_trig
    import sh_eval_pkg::*;
(
    input  logic i_clk,
    input  logic i_en,
    input  t_ang i_angle,
    output t_fx  o_cos,
    output t_fx  o_sin
);

    localparam t_red RED_FIX = t_red'(longint'(RED_K) * TWO_PI_Q30);
    localparam t_red HALF1   = t_red'(HALF_PI_Q30);
    localparam t_red HALF2   = t_red'(2 * HALF_PI_Q30);
    localparam t_red HALF3   = t_red'(3 * HALF_PI_Q30);
    localparam t_q30 ONE     = t_q30'(ONE_Q30);

    typedef struct packed {
        t_q30       f;
        t_q30       f2;
        logic [1:0] quad;
    } t_carry;

    t_red       r_red [RED_STEPS+1];
    t_q30       r_f;
    logic [1:0] r_quad;
    t_carry     r_car [2*SERIES_TERMS+1];
    t_q30       r_ps [SERIES_TERMS];
    t_q30       r_pc [SERIES_TERMS];
    t_q30       r_ts [SERIES_TERMS];
    t_q30       r_tc [SERIES_TERMS];
    t_q30       r_sv;
    t_q30       r_cv;
    logic [1:0] r_quad_o;
    t_fx        r_cos;
    t_fx        r_sin;

    t_q30       n_f;
    logic [1:0] n_quad;
    t_red       red_last;
    t_fx        n_c;
    t_fx        n_s;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_red[0] <= (i_angle < 0) ? t_red'(i_angle) + RED_FIX : t_red'(i_angle);
        end
    end

    // binary reduction mod 2pi, one conditional subtract per stage
    for (genvar s = 1; s <= RED_STEPS; s++) begin : g_red
        localparam t_red SUB = t_red'(TWO_PI_Q30 <<< (RED_STEPS - s));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_red[s] <= (r_red[s-1] >= SUB) ? r_red[s-1] - SUB : r_red[s-1];
            end
        end
    end

    assign red_last = r_red[RED_STEPS];

    always_comb begin
        if (red_last >= HALF3) begin
            n_quad = 2'd3;
            n_f    = t_q30'(red_last - HALF3);
        end else if (red_last >= HALF2) begin
            n_quad = 2'd2;
            n_f    = t_q30'(red_last - HALF2);
        end else if (red_last >= HALF1) begin
            n_quad = 2'd1;
            n_f    = t_q30'(red_last - HALF1);
        end else begin
            n_quad = 2'd0;
            n_f    = t_q30'(red_last);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f      <= n_f;
            r_quad   <= n_quad;
            r_car[0] <= '{f: r_f, f2: t_q30'(mul_fx(t_fx'(r_f), t_fx'(r_f), 30)),
                          quad: r_quad};
        end
    end

    // horner steps of both series, highest term first
    for (genvar i = 0; i < SERIES_TERMS; i++) begin : g_horner
        localparam int K  = SERIES_TERMS - i;
        localparam int DS = 2 * K * (2 * K + 1);
        localparam int DC = (2 * K - 1) * (2 * K);
        localparam int LS = $clog2(DS);
        localparam int LC = $clog2(DC);
        localparam logic [32:0] RS = 33'(((65'd1 << (32 + LS)) + 65'(DS) - 65'd1) / 65'(DS));
        localparam logic [32:0] RC = 33'(((65'd1 << (32 + LC)) + 65'(DC) - 65'd1) / 65'(DC));

        t_q30 ts_in;
        t_q30 tc_in;

        if (i == 0) begin : g_first
            assign ts_in = ONE;
            assign tc_in = ONE;
        end else begin : g_next
            assign ts_in = r_ts[i-1];
            assign tc_in = r_tc[i-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ps[i]      <= t_q30'(mul_fx(t_fx'(r_car[2*i].f2), t_fx'(ts_in), 30));
                r_pc[i]      <= t_q30'(mul_fx(t_fx'(r_car[2*i].f2), t_fx'(tc_in), 30));
                r_car[2*i+1] <= r_car[2*i];
                r_ts[i]      <= t_q30'(t_fx'(ONE) - div_const(t_fx'(r_ps[i]), RS, 32 + LS));
                r_tc[i]      <= t_q30'(t_fx'(ONE) - div_const(t_fx'(r_pc[i]), RC, 32 + LC));
                r_car[2*i+2] <= r_car[2*i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sv     <= t_q30'(mul_fx(t_fx'(r_car[2*SERIES_TERMS].f),
                                      t_fx'(r_ts[SERIES_TERMS-1]), 30));
            r_cv     <= r_tc[SERIES_TERMS-1];
            r_quad_o <= r_car[2*SERIES_TERMS].quad;
        end
    end

    always_comb begin
        case (r_quad_o)
            2'd0: begin
                n_c = t_fx'(r_cv);
                n_s = t_fx'(r_sv);
            end
            2'd1: begin
                n_c = -t_fx'(r_sv);
                n_s = t_fx'(r_cv);
            end
            2'd2: begin
                n_c = -t_fx'(r_cv);
                n_s = -t_fx'(r_sv);
            end
            default: begin
                n_c = t_fx'(r_sv);
                n_s = -t_fx'(r_cv);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= round_shift(n_c, 6);
            r_sin <= round_shift(n_s, 6);
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

### rtl/spherical_harmonic_eval_unit.sv
// Evaluates the real and imaginary parts of the spherical harmonic Y_lm for one
// bond direction per transfer. The degree l comes from the configuration register
// (reset 6, values above 8 act as 8) and may only be written while no item is in
// flight. A new item can enter every cycle while the output is not stalled. The
// depth is set by the two sine/cosine units (mod-2pi reduction, then a 2-stage
// Horner step per series term) followed by the Legendre recurrence, two stages
// per degree. A stall at the output freezes the whole pipe.
// When |m| exceeds l the result carries the invalid flag in tuser and zero parts.
module spherical_harmonic_eval_unit
    import sh_eval_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CFG_W-1:0] i_cfg_wr_data,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [39:0]      i_s_axis_tdata,  // order[4:0], polar_angle[21:5], azimuth_angle[39:22]
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [47:0]      o_m_axis_tdata,  // real_part[23:0], imag_part[47:24]
    output logic             o_m_axis_tuser   // invalid
);

    logic [CFG_W-1:0]      r_degree;
    logic [PIPE_DEPTH-1:0] r_vld;
    t_side                 r_side [TRIG_LAT+1];
    t_ang                  r_theta;
    t_ang                  r_phi;
    t_leg                  r_l1 [MAX_DEGREE];
    t_leg                  r_l2 [MAX_DEGREE];
    t_fx                   r_t  [MAX_DEGREE];
    t_fx                   r_v  [MAX_DEGREE];
    t_fx                   r_prod_re;
    t_fx                   r_prod_im;
    t_side                 r_prod_side;
    t_out                  r_out_re;
    t_out                  r_out_im;
    logic                  r_out_inv;

    logic                      adv;
    logic signed [4:0]         in_order;
    logic [16:0]               in_polar;
    logic signed [17:0]        in_azimuth;
    logic [4:0]                order_mag;
    t_deg                      deg_sat;
    t_side                     n_side;
    logic signed [18+DEG_W:0]  phi_m;
    t_fx                       th_cos;
    t_fx                       th_sin;
    t_fx                       ph_cos;
    t_fx                       ph_sin;
    t_leg                      leg_in;
    t_fx                       re_signed;
    t_fx                       im_signed;

    assign adv             = !r_vld[PIPE_DEPTH-1] || i_m_axis_tready;
    assign o_s_axis_tready = adv;

    assign in_order   = i_s_axis_tdata[4:0];
    assign in_polar   = i_s_axis_tdata[21:5];
    assign in_azimuth = i_s_axis_tdata[39:22];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= DEGREE_RESET;
        end else if (i_cfg_wr_en) begin
            r_degree <= i_cfg_wr_data;
        end
    end

    always_comb begin
        order_mag = in_order[4] ? 5'(-in_order) : 5'(in_order);
        deg_sat   = (r_degree > CFG_W'(MAX_DEGREE)) ? t_deg'(MAX_DEGREE) : t_deg'(r_degree);
        n_side.degree    = deg_sat;
        n_side.invalid   = order_mag > 5'(deg_sat);
        n_side.order_mag = n_side.invalid ? '0 : t_deg'(order_mag);
        n_side.flip      = in_order[4] & order_mag[0];
        phi_m            = in_azimuth * $signed({1'b0, n_side.order_mag});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_side[0] <= n_side;
            r_theta   <= t_ang'({in_polar, 15'd0});
            r_phi     <= t_ang'(phi_m) <<< 15;
        end
    end

    for (genvar t = 1; t <= TRIG_LAT; t++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_side[t] <= r_side[t-1];
            end
        end
    end

    sh_eval_trig u_trig_theta (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_angle (r_theta),
        .o_cos   (th_cos),
        .o_sin   (th_sin)
    );

    sh_eval_trig u_trig_phi (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_angle (r_phi),
        .o_cos   (ph_cos),
        .o_sin   (ph_sin)
    );

    always_comb begin
        leg_in.cur  = t_fx'(INV_SQRT_4PI_Q24);
        leg_in.prev = '0;
        leg_in.x    = th_cos;
        leg_in.sn   = th_sin[47] ? -th_sin : th_sin;
        leg_in.cp   = ph_cos;
        leg_in.sp   = ph_sin;
        leg_in.side = r_side[TRIG_LAT];
    end

    // recurrence stage j, step j+1: sectoral while j+1 <= m, then the first off-diagonal
    // step, then the three-term recurrence up to l
    for (genvar j = 0; j < MAX_DEGREE; j++) begin : g_leg
        localparam t_fac_row ROW_A = factor_row(j + 1, 1'b0);
        localparam t_fac_row ROW_B = factor_row(j + 1, 1'b1);
        localparam logic [DEG_W:0] STEP = (DEG_W+1)'(j + 1);

        t_leg s_in;
        t_fx  fac_a;
        t_fx  fac_b;
        t_fx  u;
        t_leg n_l2;

        if (j == 0) begin : g_first
            assign s_in = leg_in;
        end else begin : g_next
            assign s_in = r_l2[j-1];
        end

        assign fac_b = t_fx'(ROW_B[s_in.side.order_mag*FAC_W +: FAC_W]);
        assign fac_a = t_fx'(ROW_A[r_l1[j].side.order_mag*FAC_W +: FAC_W]);
        assign u     = mul_fx(fac_a, r_t[j], 24);

        always_comb begin
            n_l2 = r_l1[j];
            if (STEP <= {1'b0, r_l1[j].side.degree}) begin
                if (STEP <= {1'b0, r_l1[j].side.order_mag}) begin
                    n_l2.cur = -u;
                end else if (STEP == {1'b0, r_l1[j].side.order_mag} + 1'b1) begin
                    n_l2.prev = r_l1[j].cur;
                    n_l2.cur  = u;
                end else begin
                    n_l2.prev = r_l1[j].cur;
                    n_l2.cur  = u - r_v[j];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_l1[j] <= s_in;
                r_t[j]  <= mul_fx((STEP <= {1'b0, s_in.side.order_mag}) ? s_in.sn : s_in.x,
                                  s_in.cur, 24);
                r_v[j]  <= mul_fx(fac_b, s_in.prev, 24);
                r_l2[j] <= n_l2;
            end
        end
    end

    always_comb begin
        re_signed = r_prod_side.flip ? -r_prod_re : r_prod_re;
        im_signed = r_prod_side.flip ? -r_prod_im : r_prod_im;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_prod_re   <= mul_fx(r_l2[MAX_DEGREE-1].cur, r_l2[MAX_DEGREE-1].cp, 24);
            r_prod_im   <= mul_fx(r_l2[MAX_DEGREE-1].cur, r_l2[MAX_DEGREE-1].sp, 24);
            r_prod_side <= r_l2[MAX_DEGREE-1].side;
            r_out_re    <= r_prod_side.invalid ? '0 : to_out(re_signed);
            r_out_im    <= r_prod_side.invalid ? '0 : to_out(im_signed);
            r_out_inv   <= r_prod_side.invalid;
        end
    end

    assign o_m_axis_tvalid = r_vld[PIPE_DEPTH-1];
    assign o_m_axis_tdata  = {r_out_im, r_out_re};
    assign o_m_axis_tuser  = r_out_inv;

`ifndef SYNTHESIS
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("invalid result with nonzero parts");

    a_degree_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> r_side[0].degree <= t_deg'(MAX_DEGREE))
        else $error("degree above table range");

    a_order_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] && !r_side[0].invalid |-> r_side[0].order_mag <= r_side[0].degree)
        else $error("order above degree not flagged");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> r_vld == $past(r_vld))
        else $error("pipeline moved during output stall");
`endif

endmodule
